FILE: rtl/pizp_pkg.sv
// shared types, codes and defaults for the point-in-zone pick unit
`default_nettype none
package pizp_pkg;

    localparam int DEF_MAX_SHAPES      = 16;
    localparam int DEF_MAX_VERTICES    = 64;
    localparam int DEF_COORD_FRAC_BITS = 16;
    localparam int QUEUE_DEPTH         = 2;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SHAPE  = 2'd1,
        OP_VERTEX = 2'd2,
        OP_QUERY  = 2'd3
    } t_op;

    localparam logic [1:0] KIND_RECT    = 2'd0;
    localparam logic [1:0] KIND_ELLIPSE = 2'd1;
    localparam logic [1:0] KIND_POLY    = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_FULL     = 2'd1;
    localparam logic [1:0] STATUS_V_REJECT = 2'd2;

    typedef struct packed {
        t_op                op;
        logic [1:0]         kind;
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic [18:0]        hw;
        logic [18:0]        hh;
        logic signed [16:0] c;
        logic signed [16:0] s;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage
`default_nettype wire

FILE: rtl/pizp_ram.sv
// generic single write port ram with registered read
`default_nettype none
module pizp_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/pizp_front.sv
// command intake: decodes items and buffers them in a short queue
`default_nettype none
module pizp_front (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [1:0]           i_operation,
    input  wire logic [1:0]           i_shape_kind,
    input  wire logic signed [19:0]   i_coord_x,
    input  wire logic signed [19:0]   i_coord_y,
    input  wire logic [18:0]          i_half_width,
    input  wire logic [18:0]          i_half_height,
    input  wire logic signed [16:0]   i_cos_angle,
    input  wire logic signed [16:0]   i_sin_angle,
    input  wire logic                 i_pop,
    output pizp_pkg::t_queue_head     o_head
);
    localparam int PW = $clog2(pizp_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(pizp_pkg::QUEUE_DEPTH + 1);

    pizp_pkg::t_item r_q [pizp_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [NW-1:0]   r_cnt;
    logic            push;
    pizp_pkg::t_item in_item;

    always_comb begin
        in_item.op   = pizp_pkg::t_op'(i_operation);
        in_item.kind = i_shape_kind;
        in_item.x    = i_coord_x;
        in_item.y    = i_coord_y;
        in_item.hw   = i_half_width;
        in_item.hh   = i_half_height;
        in_item.c    = i_cos_angle;
        in_item.s    = i_sin_angle;
    end

    assign o_busy      = (r_cnt == NW'(pizp_pkg::QUEUE_DEPTH));
    assign push        = i_start && !o_busy;
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_q[r_wp] <= in_item;
                r_wp      <= (r_wp == PW'(pizp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(pizp_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_cnt != '0) else $error("pop from empty queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(pizp_pkg::QUEUE_DEPTH)) else $error("queue count overflow");
`endif
endmodule
`default_nettype wire

FILE: rtl/pizp_engine.sv
// back end: shape table, vertex store and the newest-first point scan
`default_nettype none
module pizp_engine #(
    parameter int MAX_SHAPES      = pizp_pkg::DEF_MAX_SHAPES,
    parameter int MAX_VERTICES    = pizp_pkg::DEF_MAX_VERTICES,
    parameter int COORD_FRAC_BITS = pizp_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  pizp_pkg::t_queue_head     i_head,
    output logic                      o_pop,
    output logic                      o_done,
    output logic                      o_hit,
    output logic [3:0]                o_shape_index,
    output logic [1:0]                o_status
);
    localparam int SW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CW = $clog2(MAX_SHAPES + 1);
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int AW = $clog2(MAX_SHAPES * MAX_VERTICES);
    localparam int MinHalfRnd = ((1 << COORD_FRAC_BITS) + 5000) / 10000;
    localparam logic [18:0] MIN_HALF = 19'((MinHalfRnd == 0) ? 1 : MinHalfRnd);

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_SHAPE, S_DISP, S_OFF, S_MUL, S_SUM, S_LOC,
        S_BOX, S_EPRE, S_EACC, S_ECMP, S_PRUN
    } t_state;

    t_state r_state;
    pizp_pkg::t_item r_cmd;

    // shape table
    logic [1:0]         r_kind [MAX_SHAPES];
    logic signed [19:0] r_cx   [MAX_SHAPES];
    logic signed [19:0] r_cy   [MAX_SHAPES];
    logic [18:0]        r_hx   [MAX_SHAPES];
    logic [18:0]        r_hy   [MAX_SHAPES];
    logic signed [16:0] r_cos  [MAX_SHAPES];
    logic signed [16:0] r_sin  [MAX_SHAPES];
    logic [VW-1:0]      r_vcnt [MAX_SHAPES];
    logic [CW-1:0]      r_count;
    logic [1:0]         r_last_kind;
    logic [VW-1:0]      r_last_vcnt;

    // scan
    logic [CW-1:0] r_i;
    logic [SW-1:0] r_sidx;

    // box / ellipse path
    logic signed [20:0] r_ox, r_oy;
    logic signed [37:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [38:0] r_sx, r_sy;
    logic [23:0]        r_ax, r_ay;
    logic [18:0]        r_hxc, r_hyc;
    logic [42:0]        r_p, r_q;
    logic [37:0]        r_r;
    logic [3:0]         r_step;
    logic [37:0]        r_prod;
    logic [1:0]         r_ppart;
    logic               r_pneg;
    logic signed [79:0] r_acc;

    // polygon path
    logic [VW-1:0]      r_ic, r_ec;
    logic [AW-1:0]      r_raddr;
    logic               r_v0, r_v1, r_v2, r_v3, r_f0, r_f1;
    logic signed [19:0] r_prev_x, r_prev_y;
    logic signed [20:0] r_dxa, r_d, r_dxb, r_dya;
    logic               r_cross2, r_cross3, r_dpos3, r_in;
    logic signed [41:0] r_lhs, r_rhs;

    // results
    logic          r_done, r_hit;
    logic [SW-1:0] r_idx;
    logic [1:0]    r_status;

    // vertex ram ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [39:0]   ram_wdata, ram_rdata;

    pizp_ram #(.WIDTH(40), .DEPTH(MAX_SHAPES * MAX_VERTICES)) u_vram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(r_raddr),
        .o_rdata(ram_rdata)
    );

    logic               vtx_ok;
    logic [VW-1:0]      n_vert;
    logic signed [19:0] rd_x, rd_y;
    logic signed [38:0] sx_r, sy_r;
    logic signed [23:0] lx, ly;
    logic [18:0]        op_a, op_b;
    logic [79:0]        term;
    logic               cnt_hit;
    logic [31:0]        idx_wide;

    assign n_vert = r_vcnt[r_sidx];
    assign rd_x   = ram_rdata[39:20];
    assign rd_y   = ram_rdata[19:0];
    assign vtx_ok = (r_count != '0) && (r_last_kind == pizp_pkg::KIND_POLY) &&
                    (r_last_vcnt != VW'(MAX_VERTICES));
    assign ram_we    = (r_state == S_EXEC) && (r_cmd.op == pizp_pkg::OP_VERTEX) && vtx_ok;
    assign ram_waddr = AW'((int'(r_count) - 1) * MAX_VERTICES + int'(r_last_vcnt));
    assign ram_wdata = {r_cmd.x, r_cmd.y};
    assign o_pop     = (r_state == S_IDLE) && i_head.valid;

    // round to nearest (half up) from 15 extra fraction bits
    assign sx_r = r_sx + 39'sd16384;
    assign sy_r = r_sy + 39'sd16384;
    assign lx   = sx_r[38:15];
    assign ly   = sy_r[38:15];

    // ellipse: one 19x19 partial product per step of p^2 + q^2 - r^2
    always_comb begin
        case (r_step)
            4'd0:    begin op_a = r_p[37:19]; op_b = r_p[37:19]; end
            4'd1:    begin op_a = r_p[37:19]; op_b = r_p[18:0];  end
            4'd2:    begin op_a = r_p[18:0];  op_b = r_p[18:0];  end
            4'd3:    begin op_a = r_q[37:19]; op_b = r_q[37:19]; end
            4'd4:    begin op_a = r_q[37:19]; op_b = r_q[18:0];  end
            4'd5:    begin op_a = r_q[18:0];  op_b = r_q[18:0];  end
            4'd6:    begin op_a = r_r[37:19]; op_b = r_r[37:19]; end
            4'd7:    begin op_a = r_r[37:19]; op_b = r_r[18:0];  end
            4'd8:    begin op_a = r_r[18:0];  op_b = r_r[18:0];  end
            default: begin op_a = '0;         op_b = '0;         end
        endcase
        case (r_ppart)
            2'd0:    term = {r_prod, 42'd0} >> 4;
            2'd1:    term = {22'd0, r_prod, 20'd0};
            default: term = {42'd0, r_prod};
        endcase
    end

    // crossing test result for the edge in the last stage
    assign cnt_hit = r_cross3 && (r_dpos3 ? (r_lhs < r_rhs) : (r_lhs > r_rhs));

    assign idx_wide      = 32'(r_idx);
    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_shape_index = idx_wide[3:0];
    assign o_status      = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_cmd   <= i_head.item;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_hit    <= 1'b0;
                    r_idx    <= '0;
                    r_status <= pizp_pkg::STATUS_OK;
                    r_state  <= S_IDLE;
                    r_done   <= 1'b1;
                    case (r_cmd.op)
                        pizp_pkg::OP_CLEAR: begin
                            r_count <= '0;
                        end
                        pizp_pkg::OP_SHAPE: begin
                            if (r_count == CW'(MAX_SHAPES)) begin
                                r_status <= pizp_pkg::STATUS_FULL;
                            end else begin
                                r_kind[SW'(r_count)] <= r_cmd.kind;
                                r_cx[SW'(r_count)]   <= r_cmd.x;
                                r_cy[SW'(r_count)]   <= r_cmd.y;
                                r_hx[SW'(r_count)]   <= r_cmd.hw;
                                r_hy[SW'(r_count)]   <= r_cmd.hh;
                                r_cos[SW'(r_count)]  <= r_cmd.c;
                                r_sin[SW'(r_count)]  <= r_cmd.s;
                                r_vcnt[SW'(r_count)] <= '0;
                                r_last_kind          <= r_cmd.kind;
                                r_last_vcnt          <= '0;
                                r_count              <= r_count + 1'b1;
                            end
                        end
                        pizp_pkg::OP_VERTEX: begin
                            if (!vtx_ok) begin
                                r_status <= pizp_pkg::STATUS_V_REJECT;
                            end else begin
                                r_last_vcnt <= r_last_vcnt + 1'b1;
                                r_vcnt[SW'(r_count - CW'(1))] <= r_last_vcnt + 1'b1;
                            end
                        end
                        default: begin
                            r_i     <= r_count;
                            r_done  <= 1'b0;
                            r_state <= S_SHAPE;
                        end
                    endcase
                end
                S_SHAPE: begin
                    if (r_i == '0) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_sidx  <= SW'(r_i - CW'(1));
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    if (r_kind[r_sidx] == pizp_pkg::KIND_POLY) begin
                        if (n_vert == '0) begin
                            r_i     <= r_i - 1'b1;
                            r_state <= S_SHAPE;
                        end else begin
                            r_ic    <= '0;
                            r_ec    <= '0;
                            r_in    <= 1'b0;
                            r_v0    <= 1'b0;
                            r_v1    <= 1'b0;
                            r_v2    <= 1'b0;
                            r_v3    <= 1'b0;
                            r_state <= S_PRUN;
                        end
                    end else begin
                        r_state <= S_OFF;
                    end
                end
                S_OFF: begin
                    r_ox    <= 21'(r_cmd.x) - 21'(r_cx[r_sidx]);
                    r_oy    <= 21'(r_cmd.y) - 21'(r_cy[r_sidx]);
                    r_hxc   <= (r_hx[r_sidx] < MIN_HALF) ? MIN_HALF : r_hx[r_sidx];
                    r_hyc   <= (r_hy[r_sidx] < MIN_HALF) ? MIN_HALF : r_hy[r_sidx];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_m1    <= 38'(r_ox) * 38'(r_cos[r_sidx]);
                    r_m2    <= 38'(r_oy) * 38'(r_sin[r_sidx]);
                    r_m3    <= 38'(r_oy) * 38'(r_cos[r_sidx]);
                    r_m4    <= 38'(r_ox) * 38'(r_sin[r_sidx]);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sx    <= 39'(r_m1) + 39'(r_m2);
                    r_sy    <= 39'(r_m3) - 39'(r_m4);
                    r_state <= S_LOC;
                end
                S_LOC: begin
                    r_ax    <= lx[23] ? 24'(-lx) : 24'(lx);
                    r_ay    <= ly[23] ? 24'(-ly) : 24'(ly);
                    r_state <= S_BOX;
                end
                S_BOX: begin
                    if (r_kind[r_sidx] == pizp_pkg::KIND_ELLIPSE) begin
                        r_p     <= 43'(r_ax) * 43'(r_hyc);
                        r_q     <= 43'(r_ay) * 43'(r_hxc);
                        r_r     <= 38'(r_hxc) * 38'(r_hyc);
                        r_state <= S_EPRE;
                    end else if (r_ax <= 24'(r_hxc) && r_ay <= 24'(r_hyc)) begin
                        r_hit   <= 1'b1;
                        r_idx   <= r_sidx;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_SHAPE;
                    end
                end
                S_EPRE: begin
                    // either leg alone beyond the bound rules the point out
                    if (r_p > 43'(r_r) || r_q > 43'(r_r)) begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_SHAPE;
                    end else begin
                        r_step  <= '0;
                        r_acc   <= '0;
                        r_state <= S_EACC;
                    end
                end
                S_EACC: begin
                    if (r_step != 4'd0) begin
                        r_acc <= r_pneg ? r_acc - $signed(term) : r_acc + $signed(term);
                    end
                    if (r_step == 4'd9) begin
                        r_state <= S_ECMP;
                    end else begin
                        r_prod  <= 38'(op_a) * 38'(op_b);
                        r_pneg  <= (r_step >= 4'd6);
                        case (r_step)
                            4'd0, 4'd3, 4'd6: r_ppart <= 2'd0;
                            4'd1, 4'd4, 4'd7: r_ppart <= 2'd1;
                            default:          r_ppart <= 2'd2;
                        endcase
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ECMP: begin
                    if (r_acc <= 80'sd0) begin
                        r_hit   <= 1'b1;
                        r_idx   <= r_sidx;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_i     <= r_i - 1'b1;
                        r_state <= S_SHAPE;
                    end
                end
                S_PRUN: begin
                    // issue: the closing vertex first, then vertices in order
                    if (r_ic <= n_vert) begin
                        r_raddr <= (r_ic == '0)
                            ? AW'(int'(r_sidx) * MAX_VERTICES + int'(n_vert) - 1)
                            : AW'(int'(r_sidx) * MAX_VERTICES + int'(r_ic) - 1);
                        r_f0 <= (r_ic == '0);
                        r_v0 <= 1'b1;
                        r_ic <= r_ic + 1'b1;
                    end else begin
                        r_v0 <= 1'b0;
                    end
                    r_v1 <= r_v0;
                    r_f1 <= r_f0;
                    // edge setup from the previous and the fresh vertex
                    r_v2 <= r_v1 && !r_f1;
                    if (r_v1) begin
                        r_prev_x <= rd_x;
                        r_prev_y <= rd_y;
                        r_dxa    <= 21'(r_cmd.x) - 21'(rd_x);
                        r_d      <= 21'(r_prev_y) - 21'(rd_y);
                        r_dxb    <= 21'(r_prev_x) - 21'(rd_x);
                        r_dya    <= 21'(r_cmd.y) - 21'(rd_y);
                        r_cross2 <= (rd_y > r_cmd.y) != (r_prev_y > r_cmd.y);
                    end
                    r_v3 <= r_v2;
                    if (r_v2) begin
                        r_lhs    <= 42'(r_dxa) * 42'(r_d);
                        r_rhs    <= 42'(r_dxb) * 42'(r_dya);
                        r_cross3 <= r_cross2;
                        r_dpos3  <= (r_d > 21'sd0);
                    end
                    if (r_v3) begin
                        r_in <= r_in ^ cnt_hit;
                        r_ec <= r_ec + 1'b1;
                        if (r_ec == n_vert - 1'b1) begin
                            r_v0 <= 1'b0;
                            r_v1 <= 1'b0;
                            r_v2 <= 1'b0;
                            r_v3 <= 1'b0;
                            if (r_in ^ cnt_hit) begin
                                r_hit   <= 1'b1;
                                r_idx   <= r_sidx;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i - 1'b1;
                                r_state <= S_SHAPE;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_hit |-> r_status == pizp_pkg::STATUS_OK)
        else $error("hit reported with error status");
    a_poly_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PRUN |-> r_kind[r_sidx] == pizp_pkg::KIND_POLY)
        else $error("edge scan on a non-polygon shape");
    a_hit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done && r_hit |-> CW'(r_idx) < r_count)
        else $error("hit index beyond table");
`endif
endmodule
`default_nettype wire

FILE: rtl/point_in_zone_pick_unit.sv
// top level of the point-in-zone pick unit
`default_nettype none
// Zone pick unit: a table of up to MAX_SHAPES rotated rectangles, rotated
// ellipses and polygons, with a newest-first point query. Pulse i_start with a
// command while o_busy is low; every command gives exactly one result beat,
// flagged by o_done for one cycle, in command order, and the result cannot be
// held off. A two-entry command queue lets new commands come in while the
// engine works. A query checks each ellipse with a nine-step shared 19x19
// multiplier for the exact quadratic form, and each polygon one edge per
// cycle from the vertex RAM, behind its registered read address and its
// registered read data. No clearing pass is needed after reset.
module point_in_zone_pick_unit #(
    parameter int MAX_SHAPES      = pizp_pkg::DEF_MAX_SHAPES,
    parameter int MAX_VERTICES    = pizp_pkg::DEF_MAX_VERTICES,
    parameter int COORD_FRAC_BITS = pizp_pkg::DEF_COORD_FRAC_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic [1:0]         i_operation,
    input  wire logic [1:0]         i_shape_kind,
    input  wire logic signed [19:0] i_coord_x,
    input  wire logic signed [19:0] i_coord_y,
    input  wire logic [18:0]        i_half_width,
    input  wire logic [18:0]        i_half_height,
    input  wire logic signed [16:0] i_cos_angle,
    input  wire logic signed [16:0] i_sin_angle,
    output logic                    o_done,
    output logic                    o_hit,
    output logic [3:0]              o_shape_index,
    output logic [1:0]              o_status
);
    pizp_pkg::t_queue_head head;
    logic                  pop;

    pizp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_operation  (i_operation),
        .i_shape_kind (i_shape_kind),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_half_width (i_half_width),
        .i_half_height(i_half_height),
        .i_cos_angle  (i_cos_angle),
        .i_sin_angle  (i_sin_angle),
        .i_pop        (pop),
        .o_head       (head)
    );

    pizp_engine #(
        .MAX_SHAPES     (MAX_SHAPES),
        .MAX_VERTICES   (MAX_VERTICES),
        .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .o_pop        (pop),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_shape_index(o_shape_index),
        .o_status     (o_status)
    );
endmodule
`default_nettype wire
